/* rtl/lfutr_pkg.sv */
// lfutr_pkg: shared widths, register indexes and constants for the lfu tray
// replacement block; used by the top level and its port checker
// no dependencies
`timescale 1ns / 1ps

package lfutr_pkg;

	// default sizing of the block
	localparam int MAX_SLOTS_DEF  = 16;
	localparam int SUBJECTS_DEF   = 256;
	localparam int COUNT_BITS_DEF = 16;

	// fixed payload and register widths
	localparam int SUBJ_W     = 8;
	localparam int BOOK_W     = 16;
	localparam int MISS_W     = 16;
	localparam int CAP_W      = 5;
	localparam int SCNT_W     = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_TRAY_CAPACITY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUBJECT_COUNT = 1'd1;

	// register reset values
	localparam logic [CAP_W-1:0]  RESET_CAPACITY      = 5'd4;
	localparam logic [SCNT_W-1:0] RESET_SUBJECT_COUNT = 9'd256;

	// book and miss counter limits
	localparam logic [BOOK_W-1:0] BOOK_FIRST      = 16'd1;
	localparam logic [BOOK_W-1:0] FIRST_NEXT_BOOK = 16'd2;
	localparam logic [BOOK_W-1:0] BOOK_MAX        = 16'hFFFF;
	localparam logic [MISS_W-1:0] MISS_MAX        = 16'hFFFF;

endpackage

/* rtl/lfu_tray_replacement.sv */
// lfu_tray_replacement: least-frequently-used tray with per-subject use and
// book counters, built around one scan unit under a small sequencer
// depends on lfutr_pkg
`timescale 1ns / 1ps

// usage
//   request channel: in_valid / in_stall with subject; a transfer happens at a
//   clock edge with in_valid high and in_stall low
//   result channel: out_valid / out_stall with hit, issued_book, evicted_valid,
//   evicted_subject, miss_total and bad_subject, one result per request
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
//   is tray_capacity, index 1 is subject_count; write only while idle
// timing
//   a request walks the tray one slot a cycle in the scan state, then rebuilds
//   it in the update state, passes the evict state on an eviction and waits
//   in the done state; an empty tray skips the scan, a bad subject goes
//   straight to done; in_stall stays high until the result has moved into the
//   output register
// reset
//   after arst_n rises, a clearing pass zeroes every entry of the use and book
//   memories; in_stall is high meanwhile, config writes are taken
// back-pressure
//   the output register holds a result while out_stall is high; a new request
//   is accepted meanwhile and its result waits in the sequencer until then

module lfu_tray_replacement #(
	parameter int MAX_SLOTS  = lfutr_pkg::MAX_SLOTS_DEF,
	parameter int SUBJECTS   = lfutr_pkg::SUBJECTS_DEF,
	parameter int COUNT_BITS = lfutr_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [lfutr_pkg::SUBJ_W-1:0]       subject,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               hit,
	output logic [lfutr_pkg::BOOK_W-1:0]       issued_book,
	output logic                               evicted_valid,
	output logic [lfutr_pkg::SUBJ_W-1:0]       evicted_subject,
	output logic [lfutr_pkg::MISS_W-1:0]       miss_total,
	output logic                               bad_subject,
	// config channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lfutr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lfutr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import lfutr_pkg::*;

	localparam int SLOT_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int FILL_W  = $clog2(MAX_SLOTS + 1);
	localparam int CAPC_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;
	localparam int SUBJ_AW = $clog2(SUBJECTS);
	localparam int LIM_W   = ($clog2(SUBJECTS + 1) > SCNT_W) ? $clog2(SUBJECTS + 1) : SCNT_W;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [CAPC_W-1:0]     CAP_TOP   = CAPC_W'(MAX_SLOTS);
	localparam logic [LIM_W-1:0]      SUBJ_LIM  = LIM_W'(SUBJECTS);
	localparam logic [SUBJ_AW-1:0]    CLR_LAST  = SUBJ_AW'(SUBJECTS - 1);

	// sequencer states
	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_UPDATE = 3'd3;
	localparam logic [2:0] ST_EVICT  = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]            state_q;
	logic [SUBJ_AW-1:0]    clr_q;

	// configuration registers
	logic [CAP_W-1:0]      cap_q;
	logic [SCNT_W-1:0]     scnt_q;

	// tray: subjects front first, with a copy of each one's use count
	logic [SUBJ_W-1:0]     slot_q [MAX_SLOTS];
	logic [COUNT_BITS-1:0] cnt_q  [MAX_SLOTS];
	logic [FILL_W-1:0]     fill_q;
	logic [MISS_W-1:0]     miss_q;

	// per-request working registers
	logic [SUBJ_W-1:0]     subj_q;
	logic [SLOT_AW-1:0]    idx_q;
	logic                  hit_q;
	logic [SLOT_AW-1:0]    pos_q;
	logic [FILL_W-1:0]     leq_q;
	logic [SUBJ_W-1:0]     ev_q;
	logic [COUNT_BITS-1:0] evcnt_q;

	// result waiting for the output register
	logic                  res_hit_q;
	logic [BOOK_W-1:0]     res_book_q;
	logic                  res_evv_q;
	logic [SUBJ_W-1:0]     res_evs_q;
	logic                  res_bad_q;

	// output register
	logic                  out_valid_q;
	logic                  o_hit_q;
	logic [BOOK_W-1:0]     o_book_q;
	logic                  o_evv_q;
	logic [SUBJ_W-1:0]     o_evs_q;
	logic [MISS_W-1:0]     o_miss_q;
	logic                  o_bad_q;

	// per-subject memories
	logic [COUNT_BITS-1:0] uc_mem [SUBJECTS];
	logic [BOOK_W-1:0]     nb_mem [SUBJECTS];
	logic [COUNT_BITS-1:0] uc_rd_q;
	logic [BOOK_W-1:0]     nb_rd_q;

	logic                  uc_we;
	logic [SUBJ_AW-1:0]    uc_waddr;
	logic [COUNT_BITS-1:0] uc_wdata;
	logic                  nb_we;
	logic [SUBJ_AW-1:0]    nb_waddr;
	logic [BOOK_W-1:0]     nb_wdata;

	logic                  in_xfer;
	logic                  req_bad;
	logic [CAPC_W-1:0]     cap_eff;
	logic                  tray_full;
	logic [COUNT_BITS-1:0] c_new;
	logic [BOOK_W-1:0]     book_iss;
	logic [BOOK_W-1:0]     book_nxt;
	logic [SUBJ_W-1:0]     rd_slot;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic                  scan_last;
	logic                  evict;
	logic                  rm;
	logic [SLOT_AW-1:0]    rm_pos;
	logic [FILL_W-1:0]     ins_pos;
	logic [SUBJ_W-1:0]     slot_nx [MAX_SLOTS];
	logic [COUNT_BITS-1:0] cnt_nx  [MAX_SLOTS];
	logic                  out_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// subject must sit below both the register and the memory depth
	assign req_bad = ({{(LIM_W - SUBJ_W){1'b0}}, subject} >= LIM_W'(scnt_q))
		|| ({{(LIM_W - SUBJ_W){1'b0}}, subject} >= SUBJ_LIM);

	// capacity 0 acts as 1, anything above the slot count as the slot count
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CAPC_W'(1);
		end else if (CAPC_W'(cap_q) > CAP_TOP) begin
			cap_eff = CAP_TOP;
		end else begin
			cap_eff = CAPC_W'(cap_q);
		end
	end

	assign tray_full = (CAPC_W'(fill_q) >= cap_eff);

	// saturating use count and book numbering
	assign c_new    = (uc_rd_q == COUNT_MAX) ? uc_rd_q : uc_rd_q + 1'b1;
	assign book_iss = (nb_rd_q == '0) ? BOOK_FIRST : nb_rd_q;
	always_comb begin
		if (nb_rd_q == '0) begin
			book_nxt = FIRST_NEXT_BOOK;
		end else if (nb_rd_q < BOOK_MAX) begin
			book_nxt = nb_rd_q + 1'b1;
		end else begin
			book_nxt = nb_rd_q;
		end
	end

	// scan unit: one slot a cycle
	assign rd_slot   = slot_q[idx_q];
	assign rd_cnt    = cnt_q[idx_q];
	assign scan_last = ((FILL_W'(idx_q) + FILL_W'(1)) == fill_q);

	// removal: the hit entry, or the front entry on eviction
	assign evict  = !hit_q && tray_full;
	assign rm     = hit_q || evict;
	assign rm_pos = hit_q ? pos_q : '0;

	// new entry goes behind every remaining entry whose count is not above its own;
	// the tray is sorted, so that is a count of such entries less the removed one
	always_comb begin
		if (hit_q) begin
			ins_pos = leq_q - FILL_W'(1);
		end else if (evict && (cnt_q[0] <= c_new)) begin
			ins_pos = leq_q - FILL_W'(1);
		end else begin
			ins_pos = leq_q;
		end
	end

	// rebuild: each slot picks from its lower neighbor, itself, its upper neighbor
	// or the new entry
	always_comb begin
		for (int n = 0; n < MAX_SLOTS; n++) begin
			if (FILL_W'(n) < ins_pos) begin
				if (rm && (SLOT_AW'(n) >= rm_pos)) begin
					slot_nx[n] = slot_q[(n + 1 < MAX_SLOTS) ? n + 1 : n];
					cnt_nx[n]  = cnt_q[(n + 1 < MAX_SLOTS) ? n + 1 : n];
				end else begin
					slot_nx[n] = slot_q[n];
					cnt_nx[n]  = cnt_q[n];
				end
			end else if (FILL_W'(n) == ins_pos) begin
				slot_nx[n] = subj_q;
				cnt_nx[n]  = c_new;
			end else begin
				if (rm && (SLOT_AW'((n > 0) ? n - 1 : 0) >= rm_pos)) begin
					slot_nx[n] = slot_q[n];
					cnt_nx[n]  = cnt_q[n];
				end else begin
					slot_nx[n] = slot_q[(n > 0) ? n - 1 : 0];
					cnt_nx[n]  = cnt_q[(n > 0) ? n - 1 : 0];
				end
			end
		end
	end

	// memory write ports
	always_comb begin
		uc_we    = 1'b0;
		uc_waddr = SUBJ_AW'(subj_q);
		uc_wdata = c_new;
		nb_we    = 1'b0;
		nb_waddr = SUBJ_AW'(subj_q);
		nb_wdata = book_nxt;
		unique case (state_q)
			ST_CLEAR: begin
				uc_we    = 1'b1;
				uc_waddr = clr_q;
				uc_wdata = '0;
				nb_we    = 1'b1;
				nb_waddr = clr_q;
				nb_wdata = '0;
			end
			ST_UPDATE: begin
				uc_we = 1'b1;
				nb_we = 1'b1;
			end
			ST_EVICT: begin
				uc_we    = 1'b1;
				uc_waddr = SUBJ_AW'(ev_q);
				uc_wdata = evcnt_q;
			end
			default: begin
				uc_we = 1'b0;
				nb_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (uc_we) begin
			uc_mem[uc_waddr] <= uc_wdata;
		end
		if (in_xfer) begin
			uc_rd_q <= uc_mem[SUBJ_AW'(subject)];
		end
	end

	always_ff @(posedge clk) begin
		if (nb_we) begin
			nb_mem[nb_waddr] <= nb_wdata;
		end
		if (in_xfer) begin
			nb_rd_q <= nb_mem[SUBJ_AW'(subject)];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= RESET_CAPACITY;
			scnt_q <= RESET_SUBJECT_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TRAY_CAPACITY: cap_q  <= cfg_data[CAP_W-1:0];
				REG_SUBJECT_COUNT: scnt_q <= cfg_data[SCNT_W-1:0];
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			fill_q  <= '0;
			miss_q  <= '0;
			idx_q   <= '0;
			hit_q   <= 1'b0;
			pos_q   <= '0;
			leq_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						idx_q <= '0;
						hit_q <= 1'b0;
						pos_q <= '0;
						leq_q <= '0;
						if (req_bad) begin
							state_q <= ST_DONE;
						end else if (fill_q == '0) begin
							state_q <= ST_UPDATE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_slot == subj_q) begin
						hit_q <= 1'b1;
						pos_q <= idx_q;
					end
					if (rd_cnt <= c_new) begin
						leq_q <= leq_q + 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					if (scan_last) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					// fill gains one unless an entry left
					if (!rm) begin
						fill_q <= fill_q + 1'b1;
					end
					if (!hit_q && (miss_q != MISS_MAX)) begin
						miss_q <= miss_q + 1'b1;
					end
					state_q <= evict ? ST_EVICT : ST_DONE;
				end
				ST_EVICT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// tray contents and per-request payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			subj_q     <= subject;
			res_hit_q  <= 1'b0;
			res_book_q <= '0;
			res_evv_q  <= 1'b0;
			res_evs_q  <= '0;
			res_bad_q  <= req_bad;
		end
		if (state_q == ST_UPDATE) begin
			for (int n = 0; n < MAX_SLOTS; n++) begin
				slot_q[n] <= slot_nx[n];
				cnt_q[n]  <= cnt_nx[n];
			end
			ev_q       <= slot_q[0];
			evcnt_q    <= (cnt_q[0] != '0) ? cnt_q[0] - 1'b1 : cnt_q[0];
			res_hit_q  <= hit_q;
			res_book_q <= book_iss;
			res_evv_q  <= evict;
			res_evs_q  <= evict ? slot_q[0] : '0;
		end
	end

	// output register: loads a result from the done state when empty or when its result transfers this edge
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			o_hit_q     <= 1'b0;
			o_book_q    <= '0;
			o_evv_q     <= 1'b0;
			o_evs_q     <= '0;
			o_miss_q    <= '0;
			o_bad_q     <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			o_hit_q     <= res_hit_q;
			o_book_q    <= res_book_q;
			o_evv_q     <= res_evv_q;
			o_evs_q     <= res_evs_q;
			o_miss_q    <= miss_q;
			o_bad_q     <= res_bad_q;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign hit             = o_hit_q;
	assign issued_book     = o_book_q;
	assign evicted_valid   = o_evv_q;
	assign evicted_subject = o_evs_q;
	assign miss_total      = o_miss_q;
	assign bad_subject     = o_bad_q;

endmodule

/* rtl/lfutr_chk.sv */
// lfutr_chk: port-level checks on the lfu tray replacement block, bound to
// the top level; depends on lfutr_pkg and lfu_tray_replacement
`timescale 1ns / 1ps

module lfutr_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic                               hit,
	input logic [lfutr_pkg::BOOK_W-1:0]       issued_book,
	input logic                               evicted_valid,
	input logic [lfutr_pkg::MISS_W-1:0]       miss_total,
	input logic                               bad_subject
);

	import lfutr_pkg::*;

	// a bad request leaves everything untouched and issues nothing
	a_bad_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_subject |-> !hit && !evicted_valid && (issued_book == '0))
		else $error("bad subject result carries hit, book or eviction");

	// eviction only on a miss
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted_valid |-> !hit && !bad_subject)
		else $error("eviction reported on a hit or bad request");

	// every good request issues a nonzero book
	a_book_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_subject |-> (issued_book != '0))
		else $error("good request issued book zero");

	// the miss total never goes down
	a_miss_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (miss_total >= $past(miss_total)))
		else $error("miss total decreased");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(issued_book) && $stable(hit))
		else $error("stalled result changed");

endmodule

bind lfu_tray_replacement lfutr_chk u_lfutr_chk (.*);
